>>> rtl/ppli_pkg.sv
// Shared types and constants for the ping-pong linear interpolator.
`timescale 1ns / 1ps

package ppli_pkg;

    // Field widths.
    localparam int CoordW   = 16;
    localparam int SpanW    = 24;
    localparam int ElapsedW = 25;
    localparam int DeltaW   = 16;
    localparam int CmdW     = 3;
    localparam int FracW    = 17;
    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 24;
    localparam int ProdW    = 35;
    localparam int DivSteps = 16;
    localparam int DivCntW  = 4;

    // Reset values of the configuration registers.
    localparam logic [SpanW-1:0] SpanReset = 24'd1000;

    // Command codes.
    localparam logic [CmdW-1:0] CMD_TICK  = 3'd0;
    localparam logic [CmdW-1:0] CMD_START = 3'd1;
    localparam logic [CmdW-1:0] CMD_PAUSE = 3'd2;
    localparam logic [CmdW-1:0] CMD_RESET = 3'd3;
    localparam logic [CmdW-1:0] CMD_STOP  = 3'd4;

    // Configuration register indexes.
    localparam logic [CfgIdxW-1:0] REG_START_X = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_START_Y = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_END_X   = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_END_Y   = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_SPAN    = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_TWO_WAY = 3'd5;
    localparam logic [CfgIdxW-1:0] REG_REPEAT  = 3'd6;
    localparam logic [CfgIdxW-1:0] REG_FINISH  = 3'd7;

    // Controller states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_LIMIT,
        ST_FRAC,
        ST_DIV,
        ST_MUL_X,
        ST_MUL_Y,
        ST_RND_Y,
        ST_EMIT
    } state_t;

    // Commands from the controller to the datapath; at most one is high.
    typedef struct packed {
        logic load_in;
        logic exec;
        logic limit;
        logic frac;
        logic div_step;
        logic mul_x;
        logic mul_y;
        logic rnd_y;
        logic emit;
    } ctl_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic tick_run;
        logic at_span;
        logic wrap_ok;
        logic div_last;
        logic out_free;
    } stat_t;

endpackage

>>> rtl/ppli_ctrl.sv
// Controller state machine that sequences one command through the datapath.
`timescale 1ns / 1ps

module ppli_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  ppli_pkg::stat_t stat,
    output ppli_pkg::ctl_t  ctl
);

    ppli_pkg::state_t state_reg;
    ppli_pkg::state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ppli_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ppli_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ppli_pkg::ST_DECODE;
                end
            end
            ppli_pkg::ST_DECODE:
            begin
                state_next = stat.tick_run ? ppli_pkg::ST_LIMIT : ppli_pkg::ST_EMIT;
            end
            ppli_pkg::ST_LIMIT:
            begin
                // The tween ends when the span is reached and no wrap is allowed.
                state_next = (stat.at_span && !stat.wrap_ok) ? ppli_pkg::ST_EMIT
                                                             : ppli_pkg::ST_FRAC;
            end
            ppli_pkg::ST_FRAC:
            begin
                state_next = stat.at_span ? ppli_pkg::ST_MUL_X : ppli_pkg::ST_DIV;
            end
            ppli_pkg::ST_DIV:
            begin
                if (stat.div_last)
                begin
                    state_next = ppli_pkg::ST_MUL_X;
                end
            end
            ppli_pkg::ST_MUL_X:
            begin
                state_next = ppli_pkg::ST_MUL_Y;
            end
            ppli_pkg::ST_MUL_Y:
            begin
                state_next = ppli_pkg::ST_RND_Y;
            end
            ppli_pkg::ST_RND_Y:
            begin
                state_next = ppli_pkg::ST_EMIT;
            end
            ppli_pkg::ST_EMIT:
            begin
                if (stat.out_free)
                begin
                    state_next = ppli_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ppli_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs.
    always_comb
    begin
        ctl      = '0;
        in_stall = 1'b1;
        unique case (state_reg)
            ppli_pkg::ST_IDLE:
            begin
                in_stall    = 1'b0;
                ctl.load_in = in_valid;
            end
            ppli_pkg::ST_DECODE: ctl.exec     = 1'b1;
            ppli_pkg::ST_LIMIT:  ctl.limit    = 1'b1;
            ppli_pkg::ST_FRAC:   ctl.frac     = 1'b1;
            ppli_pkg::ST_DIV:    ctl.div_step = 1'b1;
            ppli_pkg::ST_MUL_X:  ctl.mul_x    = 1'b1;
            ppli_pkg::ST_MUL_Y:  ctl.mul_y    = 1'b1;
            ppli_pkg::ST_RND_Y:  ctl.rnd_y    = 1'b1;
            ppli_pkg::ST_EMIT:   ctl.emit     = stat.out_free;
            default:
            begin
                ctl = '0;
            end
        endcase
    end

endmodule

>>> rtl/ppli_dp.sv
// Datapath: configuration, tween state, serial divider, multiplier and output register.
`timescale 1ns / 1ps

module ppli_dp (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    input  logic [ppli_pkg::CfgIdxW-1:0]       cfg_index,
    input  logic [ppli_pkg::CfgDataW-1:0]      cfg_data,
    input  logic [ppli_pkg::CmdW-1:0]          cmd,
    input  logic [ppli_pkg::DeltaW-1:0]        delta_time,
    input  ppli_pkg::ctl_t                     ctl,
    output ppli_pkg::stat_t                    stat,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [ppli_pkg::CoordW-1:0] pos_x,
    output logic signed [ppli_pkg::CoordW-1:0] pos_y,
    output logic                               pos_valid,
    output logic                               is_running,
    output logic                               done_res
);

    localparam int CW = ppli_pkg::CoordW;
    localparam int SW = ppli_pkg::SpanW;
    localparam int EW = ppli_pkg::ElapsedW;
    localparam logic signed [ppli_pkg::ProdW-1:0] ProdSigned32768 = 35'sd32768;

    // Configuration registers.
    logic [CW-1:0] start_x_reg, start_y_reg, end_x_reg, end_y_reg;
    logic [SW-1:0] span_reg;
    logic          two_way_reg, repeat_reg, finish_reg;

    // Tween state.
    logic [EW-1:0] elapsed_reg, elapsed_next;
    logic          back_reg, back_next;
    logic          active_reg, active_next;
    logic          finished_reg, finished_next;

    // Working registers for one command.
    logic [ppli_pkg::CmdW-1:0]    cmd_reg;
    logic [ppli_pkg::DeltaW-1:0]  delta_reg;
    logic [SW-1:0]                rem_reg, rem_next;
    logic [ppli_pkg::FracW-1:0]   u_reg, u_next;
    logic [ppli_pkg::DivCntW-1:0] cnt_reg, cnt_next;
    logic signed [ppli_pkg::ProdW-1:0] prod_reg, prod_next;
    logic [CW-1:0]                res_x_reg, res_x_next, res_y_reg, res_y_next;
    logic                         res_valid_reg, res_valid_next;

    // Output register.
    logic          out_valid_reg;
    logic [CW-1:0] pos_x_reg, pos_y_reg;
    logic          pos_valid_reg, running_reg, done_reg;

    // Combinational helpers.
    logic [SW-1:0]     span_eff;
    logic [EW:0]       sum_full;
    logic [EW-1:0]     sum_sat;
    logic [SW:0]       rem_shift;
    logic              div_bit;
    logic [CW-1:0]     from_x, from_y, to_x, to_y;
    logic signed [CW:0] d_x, d_y, d_sel;
    logic signed [ppli_pkg::FracW:0] u_s;
    logic signed [ppli_pkg::ProdW-1:0] mul_full, rnd_sum;
    logic [CW-1:0]     step;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_x_reg <= '0;
            start_y_reg <= '0;
            end_x_reg   <= '0;
            end_y_reg   <= '0;
            span_reg    <= ppli_pkg::SpanReset;
            two_way_reg <= 1'b0;
            repeat_reg  <= 1'b0;
            finish_reg  <= 1'b1;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                ppli_pkg::REG_START_X: start_x_reg <= cfg_data[CW-1:0];
                ppli_pkg::REG_START_Y: start_y_reg <= cfg_data[CW-1:0];
                ppli_pkg::REG_END_X:   end_x_reg   <= cfg_data[CW-1:0];
                ppli_pkg::REG_END_Y:   end_y_reg   <= cfg_data[CW-1:0];
                ppli_pkg::REG_SPAN:    span_reg    <= cfg_data[SW-1:0];
                ppli_pkg::REG_TWO_WAY: two_way_reg <= cfg_data[0];
                ppli_pkg::REG_REPEAT:  repeat_reg  <= cfg_data[0];
                ppli_pkg::REG_FINISH:  finish_reg  <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    // A span of zero behaves as one.
    assign span_eff = (span_reg == '0) ? SW'(1) : span_reg;

    // Saturating elapsed-time add.
    assign sum_full = {1'b0, elapsed_reg} + (EW+1)'(delta_reg);
    assign sum_sat  = sum_full[EW] ? '1 : sum_full[EW-1:0];

    // One restoring division step: elapsed * 2^16 / span, one quotient bit a cycle.
    assign rem_shift = {rem_reg, 1'b0};
    assign div_bit   = (rem_shift >= {1'b0, span_eff});

    // Endpoints of the current pass.
    assign from_x = back_reg ? end_x_reg : start_x_reg;
    assign from_y = back_reg ? end_y_reg : start_y_reg;
    assign to_x   = back_reg ? start_x_reg : end_x_reg;
    assign to_y   = back_reg ? start_y_reg : end_y_reg;
    assign d_x    = $signed({to_x[CW-1], to_x}) - $signed({from_x[CW-1], from_x});
    assign d_y    = $signed({to_y[CW-1], to_y}) - $signed({from_y[CW-1], from_y});

    // Shared multiplier: difference times fraction.
    assign d_sel    = ctl.mul_x ? d_x : d_y;
    assign u_s      = $signed({1'b0, u_reg});
    assign mul_full = ppli_pkg::ProdW'(d_sel) * ppli_pkg::ProdW'(u_s);

    // Round half up and drop the 16 fraction bits.
    assign rnd_sum = prod_reg + ProdSigned32768;
    assign step    = rnd_sum[CW+15:16];

    // Status to the controller.
    assign stat.tick_run = (cmd_reg == ppli_pkg::CMD_TICK) && active_reg;
    assign stat.at_span  = (elapsed_reg >= {1'b0, span_eff});
    assign stat.wrap_ok  = repeat_reg || (!back_reg && two_way_reg);
    assign stat.div_last = (cnt_reg == ppli_pkg::DivCntW'(ppli_pkg::DivSteps - 1));
    assign stat.out_free = !out_valid_reg || !out_stall;

    // Next values of the tween state and the working registers.
    always_comb
    begin
        elapsed_next   = elapsed_reg;
        back_next      = back_reg;
        active_next    = active_reg;
        finished_next  = finished_reg;
        rem_next       = rem_reg;
        u_next         = u_reg;
        cnt_next       = cnt_reg;
        prod_next      = prod_reg;
        res_x_next     = res_x_reg;
        res_y_next     = res_y_reg;
        res_valid_next = res_valid_reg;

        priority if (ctl.exec)
        begin
            res_x_next     = '0;
            res_y_next     = '0;
            res_valid_next = 1'b0;
            unique case (cmd_reg)
                ppli_pkg::CMD_TICK:
                begin
                    if (active_reg)
                    begin
                        elapsed_next = sum_sat;
                    end
                end
                ppli_pkg::CMD_START: active_next = 1'b1;
                ppli_pkg::CMD_PAUSE: active_next = 1'b0;
                ppli_pkg::CMD_RESET:
                begin
                    elapsed_next = '0;
                    back_next    = 1'b0;
                end
                ppli_pkg::CMD_STOP:
                begin
                    active_next    = 1'b0;
                    elapsed_next   = '0;
                    back_next      = 1'b0;
                    res_x_next     = start_x_reg;
                    res_y_next     = start_y_reg;
                    res_valid_next = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
        else if (ctl.limit)
        begin
            if (stat.at_span)
            begin
                if (stat.wrap_ok)
                begin
                    // Wrap once, flipping direction in ping-pong mode.
                    elapsed_next = elapsed_reg - {1'b0, span_eff};
                    if (two_way_reg)
                    begin
                        back_next = !back_reg;
                    end
                end
                else
                begin
                    // End of the tween: emit the endpoint of this pass and pause.
                    active_next    = 1'b0;
                    finished_next  = finished_reg || finish_reg;
                    res_x_next     = to_x;
                    res_y_next     = to_y;
                    res_valid_next = 1'b1;
                end
            end
        end
        else if (ctl.frac)
        begin
            cnt_next = '0;
            rem_next = elapsed_reg[SW-1:0];
            // A fraction of one when still past the span after the wrap.
            u_next   = stat.at_span ? {1'b1, {(ppli_pkg::FracW-1){1'b0}}} : '0;
        end
        else if (ctl.div_step)
        begin
            rem_next = div_bit ? SW'(rem_shift - {1'b0, span_eff}) : rem_shift[SW-1:0];
            u_next   = {1'b0, u_reg[ppli_pkg::FracW-3:0], div_bit};
            cnt_next = cnt_reg + 1'b1;
        end
        else if (ctl.mul_x)
        begin
            prod_next = mul_full;
        end
        else if (ctl.mul_y)
        begin
            res_x_next = from_x + step;
            prod_next  = mul_full;
        end
        else if (ctl.rnd_y)
        begin
            res_y_next     = from_y + step;
            res_valid_next = 1'b1;
        end
        else
        begin
        end
    end

    // Tween state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elapsed_reg  <= '0;
            back_reg     <= 1'b0;
            active_reg   <= 1'b0;
            finished_reg <= 1'b0;
        end
        else
        begin
            elapsed_reg  <= elapsed_next;
            back_reg     <= back_next;
            active_reg   <= active_next;
            finished_reg <= finished_next;
        end
    end

    // Working registers; payload only, no reset needed.
    always_ff @(posedge clk)
    begin
        if (ctl.load_in)
        begin
            cmd_reg   <= cmd;
            delta_reg <= delta_time;
        end
        rem_reg       <= rem_next;
        u_reg         <= u_next;
        cnt_reg       <= cnt_next;
        prod_reg      <= prod_next;
        res_x_reg     <= res_x_next;
        res_y_reg     <= res_y_next;
        res_valid_reg <= res_valid_next;
    end

    // Output valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctl.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload, loaded when the result transfer slot is free.
    always_ff @(posedge clk)
    begin
        if (ctl.emit)
        begin
            pos_x_reg     <= res_x_reg;
            pos_y_reg     <= res_y_reg;
            pos_valid_reg <= res_valid_reg;
            running_reg   <= active_reg;
            done_reg      <= finished_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign pos_x      = pos_x_reg;
    assign pos_y      = pos_y_reg;
    assign pos_valid  = pos_valid_reg;
    assign is_running = running_reg;
    assign done_res   = done_reg;

endmodule

>>> rtl/ping_pong_linear_interpolator.sv
// The command is decoded after its input transfer; a running tick checks the span limit,
// sets up the fraction, runs the 16-step serial divider (not when still at the span after
// the wrap), multiplies X and Y, rounds Y and loads the result. An ending tick loads
// after the limit check, other commands after decode; the load waits for a free output
// register, which keeps it while the next command is taken in the cycle after the load.
// Reset (rst_n, asynchronous, active low) restores register defaults and pauses the tween.
`timescale 1ns / 1ps

module ping_pong_linear_interpolator (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [ppli_pkg::CfgIdxW-1:0]       cfg_index,
    input  logic [ppli_pkg::CfgDataW-1:0]      cfg_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [ppli_pkg::CmdW-1:0]          cmd,
    input  logic [ppli_pkg::DeltaW-1:0]        delta_time,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [ppli_pkg::CoordW-1:0] pos_x,
    output logic signed [ppli_pkg::CoordW-1:0] pos_y,
    output logic                               pos_valid,
    output logic                               is_running,
    output logic                               done_res
);

    ppli_pkg::ctl_t  ctl;
    ppli_pkg::stat_t stat;

    // Register writes are always taken.
    assign cfg_ready = 1'b1;

    // Sequencer.
    ppli_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .ctl      (ctl)
    );

    // Arithmetic and state.
    ppli_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid && cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .cmd        (cmd),
        .delta_time (delta_time),
        .ctl        (ctl),
        .stat       (stat),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .pos_valid  (pos_valid),
        .is_running (is_running),
        .done_res   (done_res)
    );

    // The block is busy in the cycle after an input transfer.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input taken while a command was in progress");

    // The controller issues at most one datapath command per cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(ctl))
        else $error("more than one datapath command at once");

    // A result without a position carries zero coordinates.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !pos_valid) |-> (pos_x == '0 && pos_y == '0))
        else $error("nonzero position on a result without a position");

    // The done flag never falls once delivered.
    assert property (@(posedge clk) disable iff (!rst_n)
        ($past(out_valid && !out_stall && done_res) && out_valid) |-> done_res)
        else $error("done flag cleared");

endmodule

>>> tb/testbench.sv
// Self-checking testbench for the ping-pong linear interpolator, with a built-in tween predictor.
`timescale 1ns / 1ps

module testbench;
    import ppli_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int ITEM_TARGET = 1950;
    localparam int HOLD_CYCLES = 400;
    localparam int IDLE_PERCENT = 28;
    localparam int DRAIN_CYCLES = 30;
    localparam longint FRAC_ONE = 65536;
    localparam logic [ElapsedW-1:0] ELAPSED_CEILING = '1;
    localparam logic [CmdW-1:0] CMD_SPARE_FIRST = 3'd5;
    localparam logic [CmdW-1:0] CMD_SPARE_MID = 3'd6;
    localparam logic [CmdW-1:0] CMD_SPARE_LAST = 3'd7;

    // One full register set of the tween.
    typedef struct packed {
        logic signed [CoordW-1:0] start_x;
        logic signed [CoordW-1:0] start_y;
        logic signed [CoordW-1:0] end_x;
        logic signed [CoordW-1:0] end_y;
        logic [SpanW-1:0]         span;
        logic                     two_way;
        logic                     loop_on;
        logic                     finish_on;
    } tween_setup_t;

    // One result transfer as the block should present it.
    typedef struct packed {
        logic signed [CoordW-1:0] x;
        logic signed [CoordW-1:0] y;
        logic                     valid;
        logic                     running;
        logic                     done;
    } tween_result_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CfgIdxW-1:0]       cfg_index = '0;
    logic [CfgDataW-1:0]      cfg_data = '0;
    logic                     in_valid = 1'b0;
    logic                     in_stall;
    logic [CmdW-1:0]          cmd = '0;
    logic [DeltaW-1:0]        delta_time = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic signed [CoordW-1:0] pos_x;
    logic signed [CoordW-1:0] pos_y;
    logic                     pos_valid;
    logic                     is_running;
    logic                     done_res;

    // Predictor copy of the registers and the tween state.
    tween_setup_t        model_setup;
    logic [ElapsedW-1:0] model_elapsed;
    logic                model_backward;
    logic                model_running;
    logic                model_finished;
    tween_result_t       pending_moves[$];

    logic sender_idling = 1'b1;
    logic receiver_idling = 1'b1;
    logic hold_request = 1'b0;
    int   cycle_count = 0;
    int   error_count = 0;
    int   commands_sent = 0;
    int   commands_ignored = 0;
    int   results_checked = 0;
    int   setups_loaded = 0;

    ping_pong_linear_interpolator dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .cmd        (cmd),
        .delta_time (delta_time),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .pos_valid  (pos_valid),
        .is_running (is_running),
        .done_res   (done_res)
    );

    always #5 clk = ~clk;

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Point on the segment at fraction frac (Q1.16), rounded with ties upward.
    function automatic logic signed [CoordW-1:0] blend(logic signed [CoordW-1:0] from_p,
                                                      logic signed [CoordW-1:0] to_p,
                                                      longint frac);
        longint scaled;
        scaled = ((longint'(to_p) - longint'(from_p)) * frac + 32768) >>> 16;
        return CoordW'(longint'(from_p) + scaled);
    endfunction

    // Applies one command to the predicted state and returns the result it causes.
    function automatic tween_result_t advance_tween(logic [CmdW-1:0] op, logic [DeltaW-1:0] delta);
        tween_result_t            r;
        logic [SpanW-1:0]         span;
        logic [ElapsedW:0]        sum;
        longint                   frac;
        logic signed [CoordW-1:0] from_x;
        logic signed [CoordW-1:0] from_y;
        logic signed [CoordW-1:0] to_x;
        logic signed [CoordW-1:0] to_y;
        r = '0;
        span = (model_setup.span == '0) ? SpanW'(1) : model_setup.span;
        case (op)
            CMD_TICK:
                if (model_running)
                begin
                    sum = model_elapsed + delta;
                    model_elapsed = (sum > ELAPSED_CEILING) ? ELAPSED_CEILING : sum[ElapsedW-1:0];
                    if (model_elapsed >= span && !model_setup.loop_on &&
                        (model_backward || !model_setup.two_way))
                    begin
                        // The last pass is over: land on its endpoint and pause.
                        if (model_setup.finish_on)
                            model_finished = 1'b1;
                        model_running = 1'b0;
                        r.valid = 1'b1;
                        r.x = model_backward ? model_setup.start_x : model_setup.end_x;
                        r.y = model_backward ? model_setup.start_y : model_setup.end_y;
                    end
                    else
                    begin
                        // A single wrap at most; a fraction still past the span clamps to one.
                        if (model_elapsed >= span)
                        begin
                            if (model_setup.two_way)
                                model_backward = !model_backward;
                            model_elapsed = model_elapsed - span;
                        end
                        frac = (model_elapsed >= span) ? FRAC_ONE :
                               (longint'(model_elapsed) << 16) / longint'(span);
                        from_x = model_backward ? model_setup.end_x : model_setup.start_x;
                        from_y = model_backward ? model_setup.end_y : model_setup.start_y;
                        to_x = model_backward ? model_setup.start_x : model_setup.end_x;
                        to_y = model_backward ? model_setup.start_y : model_setup.end_y;
                        r.valid = 1'b1;
                        r.x = blend(from_x, to_x, frac);
                        r.y = blend(from_y, to_y, frac);
                    end
                end
            CMD_START:
                model_running = 1'b1;
            CMD_PAUSE:
                model_running = 1'b0;
            CMD_RESET:
            begin
                model_elapsed = '0;
                model_backward = 1'b0;
            end
            CMD_STOP:
            begin
                model_running = 1'b0;
                model_elapsed = '0;
                model_backward = 1'b0;
                r.valid = 1'b1;
                r.x = model_setup.start_x;
                r.y = model_setup.start_y;
            end
            default:
                ;
        endcase
        r.running = model_running;
        r.done = model_finished;
        return r;
    endfunction

    // Receiver: random stalls, or one long hold-off when the test asks for it.
    initial
    begin : result_stall_driver
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            out_stall <= receiver_idling && ($urandom_range(99) < IDLE_PERCENT);
        end
    end

    function automatic void check_field(string field, logic signed [31:0] want,
                                        logic signed [31:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0d, got %0d", field, want, got);
            error_count++;
        end
    endfunction

    // Each result transfer is matched against the oldest predicted result.
    always @(posedge clk)
    begin : result_checker
        tween_result_t want;
        if (rst_n && out_valid === 1'b1 && !out_stall)
        begin
            if (pending_moves.size() == 0)
            begin
                $error("Result transfer with no command waiting for it");
                error_count++;
            end
            else
            begin
                want = pending_moves.pop_front();
                check_field("pos_x", want.x, pos_x);
                check_field("pos_y", want.y, pos_y);
                check_field("pos_valid", want.valid, pos_valid);
                check_field("is_running", want.running, is_running);
                check_field("done_res", want.done, done_res);
                results_checked++;
            end
        end
    end

    // Offers one command, waits for its transfer and records the predicted result.
    // Valid stays high on return so that back-to-back commands need no extra edge.
    task automatic send_command(logic [CmdW-1:0] op, logic [DeltaW-1:0] delta);
        while (sender_idling && $urandom_range(99) < IDLE_PERCENT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd <= op;
        delta_time <= delta;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if ((op == CMD_TICK && !model_running) || op > CMD_STOP)
            commands_ignored++;
        pending_moves.push_back(advance_tween(op, delta));
        commands_sent++;
    endtask

    // Stops offering commands and waits until every result has come back.
    task automatic settle();
        in_valid <= 1'b0;
        while (pending_moves.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_register(logic [CfgIdxW-1:0] index, logic [CfgDataW-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    // Loads a full register set; only called with the block idle.
    task automatic program_tween(tween_setup_t s);
        settle();
        write_register(REG_START_X, CfgDataW'(s.start_x));
        write_register(REG_START_Y, CfgDataW'(s.start_y));
        write_register(REG_END_X, CfgDataW'(s.end_x));
        write_register(REG_END_Y, CfgDataW'(s.end_y));
        write_register(REG_SPAN, CfgDataW'(s.span));
        write_register(REG_TWO_WAY, CfgDataW'(s.two_way));
        write_register(REG_REPEAT, CfgDataW'(s.loop_on));
        write_register(REG_FINISH, CfgDataW'(s.finish_on));
        cfg_valid <= 1'b0;
        model_setup = s;
        setups_loaded++;
    endtask

    function automatic logic signed [CoordW-1:0] pick_coord();
        case ($urandom_range(9))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return '0;
            default: return CoordW'($urandom);
        endcase
    endfunction

    // Spans are mostly short so that passes end and wrap often.
    function automatic tween_setup_t pick_setup(int phase_no);
        tween_setup_t s;
        s.start_x = pick_coord();
        s.start_y = pick_coord();
        s.end_x = pick_coord();
        s.end_y = pick_coord();
        case (phase_no)
            0: s.span = '0;
            1: s.span = SpanW'(1);
            2: s.span = '1;
            default:
                case ($urandom_range(9))
                    0: s.span = '0;
                    1: s.span = '1;
                    2: s.span = SpanW'(1);
                    3, 4, 5: s.span = SpanW'($urandom_range(300, 2));
                    6, 7, 8: s.span = SpanW'($urandom_range(70000, 300));
                    default: s.span = SpanW'($urandom);
                endcase
        endcase
        s.two_way = 1'($urandom_range(1));
        s.loop_on = 1'($urandom_range(1));
        s.finish_on = 1'($urandom_range(1));
        return s;
    endfunction

    // Deltas scaled to the span, with full-range and extreme values mixed in.
    function automatic logic [DeltaW-1:0] pick_delta(logic [SpanW-1:0] span);
        int unsigned reach;
        int unsigned roll;
        reach = span / 3 + 1;
        if (reach > 65535)
            reach = 65535;
        roll = $urandom_range(99);
        if (roll < 55)
            return DeltaW'($urandom_range(reach));
        if (roll < 85)
            return DeltaW'($urandom);
        return roll[0] ? '1 : '0;
    endfunction

    function automatic logic [CmdW-1:0] pick_command();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 65)
            return CMD_TICK;
        if (roll < 80)
            return CMD_START;
        if (roll < 86)
            return CMD_PAUSE;
        if (roll < 91)
            return CMD_RESET;
        if (roll < 96)
            return CMD_STOP;
        return CmdW'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
    endfunction

    // Every command on a one-way pass with endpoints at the coordinate extremes.
    task automatic test_directed_commands();
        program_tween('{start_x: 16'sh8000, start_y: 16'sh7FFF, end_x: 16'sh7FFF,
                        end_y: 16'sh8000, span: 24'd1000, two_way: 1'b0, loop_on: 1'b0,
                        finish_on: 1'b1});
        send_command(CMD_TICK, 16'd100);
        send_command(CMD_START, 16'd0);
        send_command(CMD_TICK, 16'd0);
        send_command(CMD_TICK, 16'd1);
        send_command(CMD_TICK, 16'd499);
        send_command(CMD_PAUSE, 16'd0);
        send_command(CMD_TICK, 16'd5);
        send_command(CMD_START, 16'd0);
        send_command(CMD_RESET, 16'd0);
        send_command(CMD_TICK, 16'd999);
        send_command(CMD_TICK, 16'hFFFF);
        // Restart after the end: elapsed was kept, so the pass ends at once.
        send_command(CMD_START, 16'd0);
        send_command(CMD_TICK, 16'd0);
        send_command(CMD_STOP, 16'd0);
        send_command(CMD_SPARE_FIRST, 16'hFFFF);
        send_command(CMD_SPARE_MID, 16'h5555);
        send_command(CMD_SPARE_LAST, 16'hAAAA);
        send_command(CMD_START, 16'd0);
        send_command(CMD_TICK, 16'hFFFF);
    endtask

    // Zero span behaves as one; ping-pong turns once and ends on the way back.
    task automatic test_span_edges();
        program_tween('{start_x: 16'sh0123, start_y: -16'sd77, end_x: -16'sd4000,
                        end_y: 16'sh7FFF, span: 24'd0, two_way: 1'b1, loop_on: 1'b0,
                        finish_on: 1'b0});
        send_command(CMD_START, 16'd0);
        send_command(CMD_TICK, 16'd0);
        send_command(CMD_TICK, 16'd1);
        send_command(CMD_TICK, 16'd1);
        send_command(CMD_STOP, 16'd0);
    endtask

    // Looping with deltas far above the span drives elapsed into saturation.
    task automatic test_elapsed_saturation();
        tween_setup_t s;
        s = pick_setup(1);
        s.loop_on = 1'b1;
        program_tween(s);
        send_command(CMD_START, 16'd0);
        repeat (600)
            send_command(CMD_TICK, DeltaW'($urandom_range(65535, 60000)));
        send_command(CMD_STOP, 16'd0);
    endtask

    // The receiver holds off while commands keep coming, so the block fills and stalls.
    task automatic test_backpressure();
        tween_setup_t s;
        s = pick_setup(3);
        s.span = SpanW'(50);
        s.loop_on = 1'b1;
        program_tween(s);
        sender_idling = 1'b0;
        send_command(CMD_START, 16'd0);
        hold_request = 1'b1;
        repeat (40)
            send_command(CMD_TICK, pick_delta(s.span));
        settle();
        sender_idling = 1'b1;
    endtask

    // Phases of random commands under fresh random settings until enough have gone through.
    task automatic test_random_phases();
        tween_setup_t s;
        int           phase_no;
        phase_no = 0;
        while (commands_sent < ITEM_TARGET)
        begin
            s = pick_setup(phase_no);
            program_tween(s);
            // A few phases run with no idling on either side.
            sender_idling = !(phase_no >= 3 && phase_no <= 5);
            receiver_idling = sender_idling;
            send_command(CMD_START, 16'd0);
            repeat ($urandom_range(80, 30))
                send_command(pick_command(), pick_delta(s.span));
            phase_no++;
        end
        sender_idling = 1'b1;
        receiver_idling = 1'b1;
    endtask

    initial
    begin : run_tests
        model_setup = '0;
        model_setup.span = SpanReset;
        model_setup.finish_on = 1'b1;
        model_elapsed = '0;
        model_backward = 1'b0;
        model_running = 1'b0;
        model_finished = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_commands();
        test_span_edges();
        test_elapsed_saturation();
        test_backpressure();
        test_random_phases();
        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Run summary: %0d commands (%0d ignored), %0d results checked, %0d setups.",
                 commands_sent, commands_ignored, results_checked, setups_loaded);
        $display("Covered one-way, ping-pong and looping passes, zero and full spans, %s",
                 "elapsed saturation and a long output hold-off.");
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
